// ----- rtl/bdp_pkg.sv -----
// package: table geometry, entry and update types, predictor modes
`timescale 1ns / 1ps

package bdp_pkg;

  // number of direct-mapped entries, a power of two
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  // word address is 30 bits, the part above the index is the tag
  localparam int TAG_W         = 30 - IDX_W;

  localparam logic [31:0] FALL_STEP = 32'd4;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [1:0]  CTR_MAX   = 2'd3;
  localparam logic [1:0]  CTR_MIN   = 2'd0;
  localparam logic [1:0]  CTR_WEAK_T = 2'd2;

  typedef enum logic [1:0] {
    MODE_TAKEN     = 2'd0,
    MODE_NOT_TAKEN = 2'd1,
    MODE_ONE_BIT   = 2'd2,
    MODE_TWO_BIT   = 2'd3
  } mode_t;

  localparam mode_t MODE_RESET = MODE_TWO_BIT;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic [1:0]       ctr;
  } entry_t;

  typedef struct packed {
    logic        pred;
    logic        taken;
    logic        correct;
    logic [31:0] target;
    logic [31:0] correct_total;
    logic [31:0] branch_total;
    logic        wr_en;
    entry_t      wr_entry;
  } upd_t;

endpackage

// ----- rtl/bdp_table.sv -----
// prediction table: single-port-write memory, registered read, clear pass after reset
`timescale 1ns / 1ps

module bdp_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [bdp_pkg::IDX_W-1:0] rd_idx,
  input  logic                      wr_en,
  input  logic [bdp_pkg::IDX_W-1:0] wr_idx,
  input  bdp_pkg::entry_t           wr_data,
  output bdp_pkg::entry_t           rd_data,
  output logic                      busy
);
  import bdp_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  logic             clr_busy_r, clr_busy_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  entry_t           rd_data_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_widx;
  entry_t           mem_wdata;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  // clear pass owns the write port until it finishes
  assign mem_we    = clr_busy_r | wr_en;
  assign mem_widx  = clr_busy_r ? clr_idx_r : wr_idx;
  assign mem_wdata = clr_busy_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
  end

  // forward a same-edge write so back-to-back hits see fresh state
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_idx == rd_idx)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_idx];
      end
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

// ----- rtl/bdp_update.sv -----
// prediction, counter update, target select and statistics for one branch
`timescale 1ns / 1ps

module bdp_update (
  input  bdp_pkg::mode_t    mode,
  input  logic [31:0]       branch_address,
  input  logic [31:0]       next_address,
  input  logic signed [12:0] branch_offset,
  input  bdp_pkg::entry_t   entry,
  input  logic [31:0]       correct_count,
  input  logic [31:0]       branch_count,
  output bdp_pkg::upd_t     upd
);
  import bdp_pkg::*;

  logic [31:0]      fall;
  logic [31:0]      jump;
  logic             taken;
  logic [TAG_W-1:0] tag;
  logic             hit;
  logic [1:0]       ctr_new;
  logic             pred;
  logic             correct;
  logic             dynamic;

  always_comb begin
    fall    = branch_address + FALL_STEP;
    jump    = branch_address + {{19{branch_offset[12]}}, branch_offset};
    taken   = (next_address != fall);
    tag     = branch_address[31:IDX_W+2];
    hit     = entry.valid && (entry.tag == tag);
    dynamic = (mode == MODE_ONE_BIT) || (mode == MODE_TWO_BIT);

    // saturating two-bit counter, fresh entry starts at 1 if taken, else at 0
    if (hit) begin
      if (taken) begin
        ctr_new = (entry.ctr == CTR_MAX) ? CTR_MAX : entry.ctr + 2'd1;
      end else begin
        ctr_new = (entry.ctr == CTR_MIN) ? CTR_MIN : entry.ctr - 2'd1;
      end
    end else begin
      ctr_new = {1'b0, taken};
    end

    case (mode)
      MODE_TAKEN: begin
        pred       = 1'b1;
        upd.target = jump;
      end
      MODE_NOT_TAKEN: begin
        pred       = 1'b0;
        upd.target = fall;
      end
      MODE_ONE_BIT: begin
        pred       = hit & entry.last;
        upd.target = next_address;
      end
      default: begin
        pred       = hit & (entry.ctr >= CTR_WEAK_T);
        upd.target = (ctr_new >= CTR_WEAK_T) ? jump : fall;
      end
    endcase

    correct = (pred == taken);

    upd.pred    = pred;
    upd.taken   = taken;
    upd.correct = correct;
    upd.correct_total = (correct && (correct_count != COUNT_MAX)) ?
                        correct_count + 32'd1 : correct_count;
    upd.branch_total  = (branch_count != COUNT_MAX) ? branch_count + 32'd1 : branch_count;
    upd.wr_en          = dynamic;
    upd.wr_entry.valid = 1'b1;
    upd.wr_entry.tag   = tag;
    upd.wr_entry.last  = taken;
    upd.wr_entry.ctr   = ctr_new;
  end

endmodule

// ----- rtl/branch_direction_predictor.sv -----
// top level: branch direction predictor with tagged direct-mapped table
`timescale 1ns / 1ps
// throughput: one branch per cycle unless stalled, set by the single table read and
// write per branch; stage 1 register with the table read, then the result register
// reset: mode returns to two-bit counter, counts clear, then a table clear pass runs
// (one entry per cycle) with in_stall high; cfg writes still taken

module branch_direction_predictor (
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  // input channel: one resolved branch per transaction
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_branch_address,
  input  logic [31:0]        in_next_address,
  input  logic signed [12:0] in_branch_offset,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_predicted_taken,
  output logic               out_actually_taken,
  output logic               out_prediction_correct,
  output logic [31:0]        out_target_address,
  output logic [31:0]        out_correct_total,
  output logic [31:0]        out_branch_total
);
  import bdp_pkg::*;

  // mode register
  mode_t mode_r, mode_nxt;

  // stage 1: captured branch, table read in flight
  logic               s1_valid_r, s1_valid_nxt;
  logic [31:0]        s1_addr_r;
  logic [31:0]        s1_next_r;
  logic signed [12:0] s1_off_r;

  // running statistics
  logic [31:0] corr_cnt_r, corr_cnt_nxt;
  logic [31:0] br_cnt_r, br_cnt_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_pred_r;
  logic        out_taken_r;
  logic        out_corr_r;
  logic [31:0] out_target_r;
  logic [31:0] out_corr_tot_r;
  logic [31:0] out_br_tot_r;

  logic   in_accept;
  logic   s1_adv;
  logic   tbl_busy;
  entry_t tbl_rd_data;
  upd_t   upd;

  // stage 1 moves on when the result register is empty or being drained
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  // hold off new transactions during the clear pass or while stage 1 is blocked
  assign in_stall  = tbl_busy || (s1_valid_r && !s1_adv);
  assign in_accept = in_valid && !in_stall;

  bdp_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_idx  (in_branch_address[IDX_W+1:2]),
    .wr_en   (s1_adv && upd.wr_en),
    .wr_idx  (s1_addr_r[IDX_W+1:2]),
    .wr_data (upd.wr_entry),
    .rd_data (tbl_rd_data),
    .busy    (tbl_busy)
  );

  bdp_update u_update (
    .mode           (mode_r),
    .branch_address (s1_addr_r),
    .next_address   (s1_next_r),
    .branch_offset  (s1_off_r),
    .entry          (tbl_rd_data),
    .correct_count  (corr_cnt_r),
    .branch_count   (br_cnt_r),
    .upd            (upd)
  );

  always_comb begin
    mode_nxt      = cfg_wr_en ? mode_t'(cfg_wr_data) : mode_r;
    s1_valid_nxt  = in_accept | (s1_valid_r & ~s1_adv);
    corr_cnt_nxt  = s1_adv ? upd.correct_total : corr_cnt_r;
    br_cnt_nxt    = s1_adv ? upd.branch_total : br_cnt_r;
    out_valid_nxt = s1_adv | (out_valid_r & out_stall);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RESET;
      s1_valid_r  <= 1'b0;
      corr_cnt_r  <= '0;
      br_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      s1_valid_r  <= s1_valid_nxt;
      corr_cnt_r  <= corr_cnt_nxt;
      br_cnt_r    <= br_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload capture on input transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r <= in_branch_address;
      s1_next_r <= in_next_address;
      s1_off_r  <= in_branch_offset;
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pred_r     <= upd.pred;
      out_taken_r    <= upd.taken;
      out_corr_r     <= upd.correct;
      out_target_r   <= upd.target;
      out_corr_tot_r <= upd.correct_total;
      out_br_tot_r   <= upd.branch_total;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_predicted_taken    = out_pred_r;
  assign out_actually_taken     = out_taken_r;
  assign out_prediction_correct = out_corr_r;
  assign out_target_address     = out_target_r;
  assign out_correct_total      = out_corr_tot_r;
  assign out_branch_total       = out_br_tot_r;

endmodule

// ----- tb/tb_branch_direction_predictor.sv -----
// testbench for the branch direction predictor: directed and random branches in all four modes
`timescale 1ns / 1ps

module tb_branch_direction_predictor;
  import bdp_pkg::*;

  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 270;
  localparam int HOT_BRANCHES     = 48;
  localparam int SETTLE_CYCLES    = 4;    // settle time after the last result, with margin over the pipeline
  localparam int HOLD_AT_BRANCH   = 700;  // start of the long receiver hold-off
  localparam int HOLD_CYCLES      = 400;

  // one resolved branch as offered on the input channel
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] next_addr;
    logic [12:0] offset;
  } branch_t;

  // what the block is expected to report for one branch
  typedef struct packed {
    logic        pred;
    logic        taken;
    logic        correct;
    logic [31:0] target;
    logic [31:0] correct_total;
    logic [31:0] branch_total;
  } branch_outcome_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  // block inputs, all known from time zero
  logic        cfg_wr_en         = 1'b0;
  logic [1:0]  cfg_wr_data       = '0;
  logic        in_valid          = 1'b0;
  logic [31:0] in_branch_address = '0;
  logic [31:0] in_next_address   = '0;
  logic [12:0] in_branch_offset  = '0;
  logic        out_stall         = 1'b0;

  // block outputs
  logic        in_stall;
  logic        out_valid;
  logic        out_predicted_taken;
  logic        out_actually_taken;
  logic        out_prediction_correct;
  logic [31:0] out_target_address;
  logic [31:0] out_correct_total;
  logic [31:0] out_branch_total;

  branch_direction_predictor DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_branch_address      (in_branch_address),
    .in_next_address        (in_next_address),
    .in_branch_offset       (in_branch_offset),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_predicted_taken    (out_predicted_taken),
    .out_actually_taken     (out_actually_taken),
    .out_prediction_correct (out_prediction_correct),
    .out_target_address     (out_target_address),
    .out_correct_total      (out_correct_total),
    .out_branch_total       (out_branch_total)
  );

  // branches waiting to be offered, and outcomes waiting to come back
  branch_t         branch_queue[$];
  branch_outcome_t awaited_outcomes[$];

  // shadow copy of the predictor state, kept in step with accepted transactions
  mode_t            active_mode = MODE_RESET;
  bit               tbl_valid [TABLE_ENTRIES];
  logic [TAG_W-1:0] tbl_tag   [TABLE_ENTRIES];
  bit               tbl_last  [TABLE_ENTRIES];
  logic [1:0]       tbl_ctr   [TABLE_ENTRIES];
  logic [31:0]      tally_correct  = '0;
  logic [31:0]      tally_branches = '0;

  // pool of recurring branches so that table entries get reused and aliased
  logic [31:0] hot_addr [HOT_BRANCHES];
  logic [12:0] hot_off  [HOT_BRANCHES];
  int          hot_bias [HOT_BRANCHES];

  // run bookkeeping
  int branches_sent   = 0;
  int results_checked = 0;
  int taken_preds     = 0;
  int mispredicts     = 0;
  int mode_writes     = 0;
  int mismatches      = 0;

  // stretches without idling on either side
  bit send_rush = 1'b0;
  bit recv_rush = 1'b0;

  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  branch_t cur_branch;

  // expected outcome of one branch, updating the shadow state on the way
  function automatic branch_outcome_t predict_outcome(input branch_t b);
    branch_outcome_t  o;
    logic [31:0]      fall;
    logic [31:0]      jump;
    logic [29:0]      word;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    logic [1:0]       ctr;
    logic             hit;
    fall = b.addr + FALL_STEP;
    jump = b.addr + {{19{b.offset[12]}}, b.offset};
    word = b.addr[31:2];
    idx  = word[IDX_W-1:0];
    tag  = word[29:IDX_W];
    o = '0;
    o.taken  = (b.next_addr != fall);
    o.target = fall;
    case (active_mode)
      MODE_TAKEN: begin
        o.pred   = 1'b1;
        o.target = jump;
      end
      MODE_NOT_TAKEN: begin
        o.pred = 1'b0;
      end
      default: begin
        hit = tbl_valid[idx] && (tbl_tag[idx] == tag);
        if (hit) begin
          ctr    = tbl_ctr[idx];
          o.pred = (active_mode == MODE_ONE_BIT) ? tbl_last[idx] : (ctr >= CTR_WEAK_T);
          if (o.taken) begin
            ctr = (ctr == CTR_MAX) ? ctr : ctr + 2'd1;
          end else begin
            ctr = (ctr == CTR_MIN) ? ctr : ctr - 2'd1;
          end
        end else begin
          // unseen branch: predict not taken and take over the entry
          o.pred = 1'b0;
          ctr    = o.taken ? 2'd1 : 2'd0;
        end
        tbl_valid[idx] = 1'b1;
        tbl_tag[idx]   = tag;
        tbl_last[idx]  = o.taken;
        tbl_ctr[idx]   = ctr;
        if (active_mode == MODE_ONE_BIT) begin
          o.target = b.next_addr;
        end else begin
          o.target = (ctr >= CTR_WEAK_T) ? jump : fall;
        end
      end
    endcase
    o.correct = (o.pred == o.taken);
    if (o.correct && tally_correct != COUNT_MAX) tally_correct = tally_correct + 1;
    if (tally_branches != COUNT_MAX) tally_branches = tally_branches + 1;
    o.correct_total = tally_correct;
    o.branch_total  = tally_branches;
    return o;
  endfunction

  function automatic branch_t branch_of(input logic [31:0] addr, input logic [31:0] next_addr,
                                        input logic [12:0] offset);
    branch_t b;
    b.addr      = addr;
    b.next_addr = next_addr;
    b.offset    = offset;
    return b;
  endfunction

  // mostly recurring branches with biased outcomes, some unaligned, some pure noise
  function automatic branch_t make_random_branch();
    branch_t b;
    int      r;
    int      h;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      b.addr      = $urandom;
      b.offset    = 13'($urandom);
      b.next_addr = $urandom_range(0, 1) ? b.addr + FALL_STEP : $urandom;
    end else begin
      h = $urandom_range(0, HOT_BRANCHES - 1);
      b.addr   = hot_addr[h];
      b.offset = (r % 10 == 0) ? 13'($urandom) : hot_off[h];
      if (r < 30) b.addr[1:0] = 2'($urandom);
      if ($urandom_range(0, 99) < hot_bias[h]) begin
        b.next_addr = b.addr + {{19{b.offset[12]}}, b.offset};
      end else begin
        b.next_addr = b.addr + FALL_STEP;
      end
      if (r >= 30 && r < 35) b.next_addr = $urandom;
    end
    return b;
  endfunction

  // register write, only ever issued while nothing is in flight
  task automatic set_mode(input mode_t m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    active_mode = m;
    mode_writes++;
  endtask

  // wait until every queued branch went in and every outcome came back
  // sampled on the falling edge so the driver's updates have all settled
  task automatic wait_until_quiet();
    while (branch_queue.size() != 0 || in_valid || awaited_outcomes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // driver: offers queued branches, with a random gap (none while send_rush) drawn after each transaction
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        // transaction accepted at this edge
        awaited_outcomes.push_back(predict_outcome(cur_branch));
        branches_sent++;
        gap = send_rush ? 0 : $urandom_range(0, 11);
      end else begin
        gap = send_gap;
      end
      if (gap == 0 && branch_queue.size() != 0) begin
        cur_branch = branch_queue.pop_front();
        in_valid          <= 1'b1;
        in_branch_address <= cur_branch.addr;
        in_next_address   <= cur_branch.next_addr;
        in_branch_offset  <= cur_branch.offset;
        send_gap = 0;
      end else begin
        in_valid <= 1'b0;
        send_gap = (gap == 0) ? 0 : gap - 1;
      end
    end
  end

  // long receiver hold-off once the run is well under way, so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && branches_sent >= HOLD_AT_BRANCH) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each result transaction against the oldest expectation
  always @(posedge clk) begin
    branch_outcome_t want;
    int              wait_cycles;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result transaction with no branch outstanding");
          mismatches++;
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("predicted_taken", 32'(want.pred), 32'(out_predicted_taken));
          check_field("actually_taken", 32'(want.taken), 32'(out_actually_taken));
          check_field("prediction_correct", 32'(want.correct), 32'(out_prediction_correct));
          check_field("target_address", want.target, out_target_address);
          check_field("correct_total", want.correct_total, out_correct_total);
          check_field("branch_total", want.branch_total, out_branch_total);
          results_checked++;
          if (want.pred) taken_preds++;
          if (!want.correct) mispredicts++;
        end
        wait_cycles = recv_rush ? 0 : $urandom_range(0, 11);
      end else begin
        wait_cycles = (recv_gap == 0) ? 0 : recv_gap - 1;
      end
      recv_gap = wait_cycles;
      out_stall <= (wait_cycles != 0) || (hold_left != 0);
    end
  end

  // stimulus
  initial begin
    logic [31:0] base;
    logic [31:0] alias_addr;
    logic [31:0] tmp;
    mode_t       phase_mode [RANDOM_PHASES];
    phase_mode = '{MODE_TWO_BIT, MODE_ONE_BIT, MODE_TAKEN,
                   MODE_TWO_BIT, MODE_NOT_TAKEN, MODE_ONE_BIT};
    base       = 32'h0000_1000;
    alias_addr = base + (TABLE_ENTRIES << 2);

    // recurring branches; every third one shares its index with the one before
    for (int i = 0; i < HOT_BRANCHES; i++) begin
      tmp = $urandom & ~32'h3;
      if (i % 3 == 2) tmp[IDX_W+1:0] = hot_addr[i-1][IDX_W+1:0];
      hot_addr[i] = tmp;
      hot_off[i]  = 13'($urandom);
      hot_bias[i] = $urandom_range(0, 4) * 25;
    end

    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // written while the table clear pass still runs
    set_mode(MODE_TWO_BIT);

    // counter walks up to saturation and back down, targets follow the counter
    repeat (4) branch_queue.push_back(branch_of(base, base + 32'h100, 13'h0100));
    branch_queue.push_back(branch_of(base, base + 32'd4, 13'h0100));
    // low address bits ignored: shares the entry with the aligned branch
    branch_queue.push_back(branch_of(base + 32'd2, base + 32'd6, 13'h0100));
    repeat (2) branch_queue.push_back(branch_of(base, base + 32'd4, 13'h0100));
    // same index, other tag: evicts, then the original misses again
    branch_queue.push_back(branch_of(alias_addr, alias_addr + 32'h40, 13'h0040));
    branch_queue.push_back(branch_of(base, base + 32'h100, 13'h0100));
    // fall-through and jump sums wrapping around the address space
    branch_queue.push_back(branch_of(32'hFFFF_FFFC, 32'h0000_0000, 13'h0FFF));
    branch_queue.push_back(branch_of(32'hFFFF_FFFC, 32'hFFFF_EFFC, 13'h1000));
    branch_queue.push_back(branch_of(32'h0000_0000, 32'hFFFF_F000, 13'h1000));
    branch_queue.push_back(branch_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF));
    wait_until_quiet();

    // fixed modes leave the table alone
    set_mode(MODE_TAKEN);
    branch_queue.push_back(branch_of(32'h0000_0000, 32'h0000_0004, 13'h0FFF));
    branch_queue.push_back(branch_of(32'hFFFF_FFFC, 32'hFFFF_EFFC, 13'h1000));
    branch_queue.push_back(branch_of(base, base + 32'h100, 13'h0100));
    wait_until_quiet();

    set_mode(MODE_NOT_TAKEN);
    branch_queue.push_back(branch_of(base, base + 32'h100, 13'h0100));
    branch_queue.push_back(branch_of(32'hFFFF_FFFC, 32'h0000_0000, 13'h0FFF));
    branch_queue.push_back(branch_of(32'hFFFF_FFFF, 32'h0000_0003, 13'h0000));
    wait_until_quiet();

    // one-bit mode picks up the entry the counter mode left behind
    set_mode(MODE_ONE_BIT);
    branch_queue.push_back(branch_of(base, base + 32'h100, 13'h0100));
    branch_queue.push_back(branch_of(base, base + 32'd4, 13'h0100));
    branch_queue.push_back(branch_of(base, base + 32'h100, 13'h0100));
    branch_queue.push_back(branch_of(alias_addr, alias_addr + 32'd4, 13'h0040));
    branch_queue.push_back(branch_of(base, base + 32'h100, 13'h0100));
    wait_until_quiet();

    // random phases, one mode each, three of them with no idling on one or both sides
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      send_rush = (p == 1) || (p == 4);
      recv_rush = (p == 1) || (p == 3);
      set_mode(phase_mode[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) branch_queue.push_back(make_random_branch());
      wait_until_quiet();
    end

    $display("checked %0d branches over %0d mode settings, %0d predicted taken, %0d mispredicted",
             results_checked, mode_writes, taken_preds, mispredicts);
    $display("receiver held off for %0d cycles once while branches kept coming", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("tb_branch_direction_predictor OK");
    end else begin
      $display("tb_branch_direction_predictor NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_branch_direction_predictor NOT OK");
    $finish;
  end

endmodule
